[rtl/indexed_priority_heap_top_macros.svh]
// assertion macros shared by the heap controller and datapath
// depends on nothing; taken in by `include
`ifndef INDEXED_PRIORITY_HEAP_TOP_MACROS_SVH
`define INDEXED_PRIORITY_HEAP_TOP_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define IPH_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("heap assertion failed");

// next-cycle implication under synchronous active-low reset
`define IPH_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("heap assertion failed");

`endif

[rtl/iph_pkg.sv]
// types and codes for the indexed priority heap
// used by every module of the block but iph_ram
package iph_pkg;

  localparam int HANDLE_W = 6;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 7;

  localparam logic [2:0] ACT_PUSH   = 3'd0;
  localparam logic [2:0] ACT_POP    = 3'd1;
  localparam logic [2:0] ACT_REMOVE = 3'd2;
  localparam logic [2:0] ACT_UPDATE = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_PRESENT   = 3'd4;

  typedef struct packed {
    logic [2:0]          action;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key;
  } in_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [HANDLE_W-1:0] popped_handle;
    logic [KEY_W-1:0]    popped_key;
    logic                top_valid;
    logic [HANDLE_W-1:0] top_handle;
    logic [KEY_W-1:0]    top_key;
    logic                present;
    logic [COUNT_W-1:0]  count;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_PUSH_INIT,
    OP_RD_TOP,
    OP_POP_TAKE,
    OP_RD_POS,
    OP_REM_TAKE,
    OP_UPD_INIT,
    OP_RD_LAST,
    OP_LAST_LOAD,
    OP_RD_PARENT,
    OP_UP_STEP,
    OP_RD_LEFT,
    OP_CAP_LEFT,
    OP_DOWN_STEP,
    OP_FINISH,
    OP_CLEAR,
    OP_CAP_TOP,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       set_st;
    logic [2:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       in_range;
    logic       queued;
    logic       empty;
    logic       full;
    logic       i_zero;
    logic       left_ok;
    logic       up_win;
    logic       dn_win;
    logic       p_last;
    logic       out_busy;
  } dp_flags_t;

endpackage

[rtl/iph_ram.sv]
// generic single-write, single-read memory with registered read data
// depends on nothing
module iph_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/iph_dp.sv]
// heap datapath: slot and position memories, queued bits, sift registers, result
// depends on iph_pkg, iph_ram and the assertion macro header
`include "indexed_priority_heap_top_macros.svh"

module iph_dp #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_COUNT = 64,
  parameter int KEY_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iph_pkg::in_t         in_data,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  iph_pkg::dp_cmd_t     cmd,
  output iph_pkg::dp_flags_t   flags,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iph_pkg::out_t        out_data
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int HW  = $clog2(HANDLE_COUNT);
  localparam int HF  = iph_pkg::HANDLE_W;
  localparam int KF  = iph_pkg::KEY_W;
  localparam int HXW = (HW > HF) ? HW : HF;
  localparam int KXW = (KEY_BITS > KF) ? KEY_BITS : KF;
  localparam int SW  = HF + KEY_BITS;
  localparam int LW  = IW + 2;

  function automatic logic [HW-1:0] hix(input logic [HF-1:0] h);
    hix = HW'(HXW'(h));
  endfunction

  iph_pkg::in_t          in_r;
  logic                  ord_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [IW-1:0]         p_r, p_nxt;
  logic [HF-1:0]         cur_h_r, cur_h_nxt;
  logic [KEY_BITS-1:0]   cur_k_r, cur_k_nxt;
  logic [HF-1:0]         lh_r, lh_nxt;
  logic [KEY_BITS-1:0]   lk_r, lk_nxt;
  logic [HF-1:0]         pop_h_r, pop_h_nxt;
  logic [KEY_BITS-1:0]   pop_k_r, pop_k_nxt;
  logic [HF-1:0]         top_h_r, top_h_nxt;
  logic [KEY_BITS-1:0]   top_k_r, top_k_nxt;
  logic [2:0]            st_r, st_nxt;
  logic [HANDLE_COUNT-1:0] hq_r, hq_nxt;
  iph_pkg::out_t         out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  s_we;
  logic [IW-1:0]         s_waddr, s_raddr;
  logic [SW-1:0]         s_wdata, s_rdata;
  logic                  p_we;
  logic [HW-1:0]         p_waddr, p_raddr;
  logic [IW-1:0]         p_wdata, p_rdata;

  logic [HF-1:0]         srd_h;
  logic [KEY_BITS-1:0]   srd_k, in_key;
  logic [LW-1:0]         left_w, right_w, cnt_x;
  logic [IW-1:0]         parent_w, best_i;
  logic                  right_ok, take_right, in_range;
  logic [HF-1:0]         best_h;
  logic [KEY_BITS-1:0]   best_k;

  function automatic logic precedes(input logic ord, input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    precedes = ord ? (a > b) : (a < b);
  endfunction

  iph_ram #(.W(SW), .D(CAPACITY)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  iph_ram #(.W(IW), .D(HANDLE_COUNT)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  assign srd_h    = s_rdata[SW-1:KEY_BITS];
  assign srd_k    = s_rdata[KEY_BITS-1:0];
  assign in_key   = KEY_BITS'(KXW'(in_r.key));
  assign in_range = 32'(in_r.handle) < HANDLE_COUNT;
  assign left_w   = {1'b0, i_r, 1'b1};
  assign right_w  = left_w + LW'(1);
  assign cnt_x    = LW'(cnt_r);
  assign parent_w = (i_r - IW'(1)) >> 1;
  assign right_ok = right_w < cnt_x;

  // right child sits on the slot read port in the cycle after the left capture
  assign take_right = right_ok && precedes(ord_r, srd_k, lk_r);
  assign best_h = take_right ? srd_h : lh_r;
  assign best_k = take_right ? srd_k : lk_r;
  assign best_i = take_right ? right_w[IW-1:0] : left_w[IW-1:0];

  always_comb begin
    flags.action   = in_r.action;
    flags.in_range = in_range;
    flags.queued   = in_range && hq_r[hix(in_r.handle)];
    flags.empty    = (cnt_r == '0);
    flags.full     = (cnt_r >= CW'(CAPACITY));
    flags.i_zero   = (i_r == '0);
    flags.left_ok  = left_w < cnt_x;
    flags.up_win   = precedes(ord_r, cur_k_r, srd_k);
    flags.dn_win   = precedes(ord_r, best_k, cur_k_r);
    flags.p_last   = ((IW + 1)'(p_r) == (IW + 1)'(cnt_r));
    flags.out_busy = out_valid_r && out_stall;
  end

  always_comb begin
    s_raddr = '0;
    case (cmd.op)
      iph_pkg::OP_RD_LAST:   s_raddr = IW'(cnt_r);
      iph_pkg::OP_RD_PARENT: s_raddr = parent_w;
      iph_pkg::OP_RD_LEFT:   s_raddr = left_w[IW-1:0];
      iph_pkg::OP_CAP_LEFT:  s_raddr = right_w[IW-1:0];
      default:               s_raddr = '0;
    endcase
  end

  always_comb begin
    p_raddr   = hix(in_r.handle);
    s_we      = 1'b0;
    s_waddr   = i_r;
    s_wdata   = {cur_h_r, cur_k_r};
    p_we      = 1'b0;
    p_waddr   = hix(cur_h_r);
    p_wdata   = i_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    cur_h_nxt = cur_h_r;
    cur_k_nxt = cur_k_r;
    lh_nxt    = lh_r;
    lk_nxt    = lk_r;
    pop_h_nxt = pop_h_r;
    pop_k_nxt = pop_k_r;
    top_h_nxt = top_h_r;
    top_k_nxt = top_k_r;
    hq_nxt    = hq_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (cmd.op)
      iph_pkg::OP_LATCH: begin
        pop_h_nxt = '0;
        pop_k_nxt = '0;
      end
      iph_pkg::OP_PUSH_INIT: begin
        cur_h_nxt = in_r.handle;
        cur_k_nxt = in_key;
        i_nxt     = IW'(cnt_r);
        cnt_nxt   = cnt_r + CW'(1);
        hq_nxt[hix(in_r.handle)] = 1'b1;
      end
      iph_pkg::OP_POP_TAKE: begin
        pop_h_nxt = srd_h;
        pop_k_nxt = srd_k;
        hq_nxt[hix(srd_h)] = 1'b0;
        cnt_nxt   = cnt_r - CW'(1);
        p_nxt     = '0;
      end
      iph_pkg::OP_REM_TAKE: begin
        p_nxt   = p_rdata;
        hq_nxt[hix(in_r.handle)] = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
      end
      iph_pkg::OP_UPD_INIT: begin
        i_nxt     = p_rdata;
        cur_h_nxt = in_r.handle;
        cur_k_nxt = in_key;
      end
      iph_pkg::OP_LAST_LOAD: begin
        cur_h_nxt = srd_h;
        cur_k_nxt = srd_k;
        i_nxt     = p_r;
      end
      iph_pkg::OP_UP_STEP: begin
        s_we    = 1'b1;
        s_wdata = s_rdata;
        p_we    = 1'b1;
        p_waddr = hix(srd_h);
        i_nxt   = parent_w;
      end
      iph_pkg::OP_CAP_LEFT: begin
        lh_nxt = srd_h;
        lk_nxt = srd_k;
      end
      iph_pkg::OP_DOWN_STEP: begin
        s_we    = 1'b1;
        s_wdata = {best_h, best_k};
        p_we    = 1'b1;
        p_waddr = hix(best_h);
        i_nxt   = best_i;
      end
      iph_pkg::OP_FINISH: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      iph_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
        hq_nxt  = '0;
      end
      iph_pkg::OP_CAP_TOP: begin
        top_h_nxt = srd_h;
        top_k_nxt = srd_k;
      end
      iph_pkg::OP_LOAD_OUT: begin
        out_nxt.status        = st_r;
        out_nxt.popped_handle = pop_h_r;
        out_nxt.popped_key    = KF'(KXW'(pop_k_r));
        out_nxt.top_valid     = !flags.empty;
        out_nxt.top_handle    = flags.empty ? '0 : top_h_r;
        out_nxt.top_key       = flags.empty ? '0 : KF'(KXW'(top_k_r));
        out_nxt.present       = flags.queued;
        out_nxt.count         = iph_pkg::COUNT_W'(cnt_r);
        out_valid_nxt         = 1'b1;
      end
      iph_pkg::OP_NONE, iph_pkg::OP_RD_TOP, iph_pkg::OP_RD_POS,
      iph_pkg::OP_RD_LAST, iph_pkg::OP_RD_PARENT, iph_pkg::OP_RD_LEFT: begin
      end
      default: begin
      end
    endcase
  end

  assign st_nxt = cmd.set_st ? cmd.st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r       <= 1'b0;
      cnt_r       <= '0;
      hq_r        <= '0;
      out_valid_r <= 1'b0;
      st_r        <= iph_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        ord_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      hq_r        <= hq_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == iph_pkg::OP_LATCH) begin
      in_r <= in_data;
    end
    i_r     <= i_nxt;
    p_r     <= p_nxt;
    cur_h_r <= cur_h_nxt;
    cur_k_r <= cur_k_nxt;
    lh_r    <= lh_nxt;
    lk_r    <= lk_nxt;
    pop_h_r <= pop_h_nxt;
    pop_k_r <= pop_k_nxt;
    top_h_r <= top_h_nxt;
    top_k_r <= top_k_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IPH_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY))
  `IPH_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.op == iph_pkg::OP_LOAD_OUT, out_valid_r)

endmodule

[rtl/iph_ctrl.sv]
// heap sequencer: decodes the action and steps the sift loops
// depends on iph_pkg and the assertion macro header
`include "indexed_priority_heap_top_macros.svh"

module iph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  iph_pkg::dp_flags_t flags,
  output iph_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_CAP, S_POS_CAP, S_TAKE, S_LAST_CAP, S_UP, S_UP_CMP,
    S_DOWN, S_DN_L, S_DN_R, S_FIN, S_TOP_RD, S_TOP_CAP, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = iph_pkg::OP_NONE;
    cmd.set_st = 1'b0;
    cmd.st     = iph_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = iph_pkg::OP_LATCH;
          cmd.set_st = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt  = S_TOP_RD;
        cmd.set_st = 1'b1;
        case (flags.action)
          iph_pkg::ACT_PUSH: begin
            if (!flags.in_range) begin
              cmd.st = iph_pkg::ST_NOT_FOUND;
            end else if (flags.queued) begin
              cmd.st = iph_pkg::ST_PRESENT;
            end else if (flags.full) begin
              cmd.st = iph_pkg::ST_FULL;
            end else begin
              cmd.op    = iph_pkg::OP_PUSH_INIT;
              state_nxt = S_UP;
            end
          end
          iph_pkg::ACT_POP: begin
            if (flags.empty) begin
              cmd.st = iph_pkg::ST_EMPTY;
            end else begin
              cmd.op    = iph_pkg::OP_RD_TOP;
              state_nxt = S_POP_CAP;
            end
          end
          iph_pkg::ACT_REMOVE, iph_pkg::ACT_UPDATE: begin
            if (!flags.queued) begin
              cmd.st = iph_pkg::ST_NOT_FOUND;
            end else begin
              cmd.op    = iph_pkg::OP_RD_POS;
              state_nxt = S_POS_CAP;
            end
          end
          iph_pkg::ACT_QUERY: begin
            cmd.st = flags.queued ? iph_pkg::ST_OK : iph_pkg::ST_NOT_FOUND;
          end
          iph_pkg::ACT_CLEAR: begin
            cmd.op = iph_pkg::OP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_POP_CAP: begin
        cmd.op    = iph_pkg::OP_POP_TAKE;
        state_nxt = S_TAKE;
      end
      S_POS_CAP: begin
        if (flags.action == iph_pkg::ACT_REMOVE) begin
          cmd.op    = iph_pkg::OP_REM_TAKE;
          state_nxt = S_TAKE;
        end else begin
          cmd.op    = iph_pkg::OP_UPD_INIT;
          state_nxt = S_UP;
        end
      end
      S_TAKE: begin
        if (flags.p_last) begin
          state_nxt = S_TOP_RD;
        end else begin
          cmd.op    = iph_pkg::OP_RD_LAST;
          state_nxt = S_LAST_CAP;
        end
      end
      S_LAST_CAP: begin
        cmd.op    = iph_pkg::OP_LAST_LOAD;
        state_nxt = S_UP;
      end
      S_UP: begin
        if (flags.i_zero) begin
          state_nxt = S_DOWN;
        end else begin
          cmd.op    = iph_pkg::OP_RD_PARENT;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (flags.up_win) begin
          cmd.op    = iph_pkg::OP_UP_STEP;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DOWN;
        end
      end
      S_DOWN: begin
        if (flags.left_ok) begin
          cmd.op    = iph_pkg::OP_RD_LEFT;
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DN_L: begin
        cmd.op    = iph_pkg::OP_CAP_LEFT;
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        if (flags.dn_win) begin
          cmd.op    = iph_pkg::OP_DOWN_STEP;
          state_nxt = S_DOWN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op    = iph_pkg::OP_FINISH;
        state_nxt = S_TOP_RD;
      end
      S_TOP_RD: begin
        cmd.op    = iph_pkg::OP_RD_TOP;
        state_nxt = S_TOP_CAP;
      end
      S_TOP_CAP: begin
        cmd.op    = iph_pkg::OP_CAP_TOP;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!flags.out_busy) begin
          cmd.op    = iph_pkg::OP_LOAD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `IPH_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

[rtl/indexed_priority_heap_top.sv]
// Indexed binary-heap priority queue of job handles with keys, min-first or
// max-first by cfg_data. One transaction in gives one transaction out. A
// transaction that moves nothing (query, clear, refused action) goes from decode
// through the top read and capture to the output; a push, pop, remove or update
// adds sift loops that read the parent per level sifted up and both children per
// level sifted down, paced by the single read port of the slot memory. A new
// transaction is taken while the previous result still waits on out_stall.
// No clearing pass follows reset. Depends on iph_pkg, iph_ctrl, iph_dp, iph_ram.
module indexed_priority_heap_top #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_COUNT = 64,
  parameter int KEY_BITS     = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  iph_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output iph_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_data
);

  iph_pkg::dp_cmd_t   cmd;
  iph_pkg::dp_flags_t flags;

  iph_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .flags(flags), .cmd(cmd)
  );

  iph_dp #(
    .CAPACITY(CAPACITY), .HANDLE_COUNT(HANDLE_COUNT), .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .cmd(cmd), .flags(flags), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );

endmodule
